// ===== hw/rtl/tscw_pkg.sv =====
// Package: widths, register indexes and payload types of the thumbnail size and crop block.
package tscw_pkg;

  localparam int DIM_BITS = 14;
  // Widest ceiling-division numerator: a product of two dimensions plus the denominator.
  localparam int NUM_W    = 2 * DIM_BITS + 1;
  // The divider resolves one quotient bit per stage.
  localparam int DIV_LAT  = NUM_W;
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_BOX_WIDTH   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_BOX_HEIGHT  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_CROP_ENABLE = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_MIN_WIDTH   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_MIN_HEIGHT  = IDX_W'(4);

  typedef struct packed {
    logic [DIM_BITS-1:0] full_width;
    logic [DIM_BITS-1:0] full_height;
  } in_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] target_width;
    logic [DIM_BITS-1:0] target_height;
    logic [DIM_BITS-1:0] area_x;
    logic [DIM_BITS-1:0] area_y;
    logic [DIM_BITS-1:0] area_width;
    logic [DIM_BITS-1:0] area_height;
    logic                size_error;
  } out_t;

endpackage

// ===== hw/rtl/tscw_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module tscw_div (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [tscw_pkg::NUM_W-1:0]    num,
  input  logic [tscw_pkg::DIM_BITS-1:0] den,
  output logic [tscw_pkg::NUM_W-1:0]    quo
);

  logic [tscw_pkg::DIM_BITS-1:0] rem_r [tscw_pkg::DIV_LAT];
  logic [tscw_pkg::NUM_W-1:0]    num_r [tscw_pkg::DIV_LAT];
  logic [tscw_pkg::NUM_W-1:0]    quo_r [tscw_pkg::DIV_LAT];
  logic [tscw_pkg::DIM_BITS-1:0] den_r [tscw_pkg::DIV_LAT];

  for (genvar k = 0; k < tscw_pkg::DIV_LAT; k++) begin : g_stage
    logic [tscw_pkg::DIM_BITS-1:0] rem_in;
    logic [tscw_pkg::NUM_W-1:0]    num_in;
    logic [tscw_pkg::NUM_W-1:0]    quo_in;
    logic [tscw_pkg::DIM_BITS-1:0] den_in;
    logic [tscw_pkg::DIM_BITS:0]   sh;
    logic [tscw_pkg::DIM_BITS:0]   diff;
    logic                          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign sh   = {rem_in, num_in[tscw_pkg::NUM_W-1]};
    assign ge   = sh >= {1'b0, den_in};
    assign diff = sh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? diff[tscw_pkg::DIM_BITS-1:0] : sh[tscw_pkg::DIM_BITS-1:0];
        num_r[k] <= {num_in[tscw_pkg::NUM_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[tscw_pkg::NUM_W-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo = quo_r[tscw_pkg::DIV_LAT-1];

endmodule

// ===== hw/rtl/thumbnail_size_and_crop_window.sv =====
// Top level: thumbnail target size and source crop window, fully pipelined.
// One size request is taken every cycle while the output is not stalled; its result
// passes through two bit-per-stage divider lines of 29 stages each, one for the
// box fit and one for the crop window, plus six stages of multiply, compare and
// select. A stall at the output freezes the whole pipeline, so nothing is lost.
// Configuration writes are taken every cycle, but the registers feed several
// stages directly, so write them only while no transaction is in flight.
module thumbnail_size_and_crop_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tscw_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tscw_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tscw_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tscw_pkg::DIM_BITS-1:0] cfg_data
);

  localparam int D = tscw_pkg::DIM_BITS;
  localparam int N = tscw_pkg::NUM_W;
  localparam int L = tscw_pkg::DIV_LAT;

  typedef struct packed {
    logic [D-1:0] fw;
    logic [D-1:0] fh;
    logic         err;
  } side_a_t;

  typedef struct packed {
    logic [D-1:0] tw;
    logic [D-1:0] th;
    logic [D-1:0] fw;
    logic [D-1:0] fh;
    logic         err;
    logic         gt;
    logic         dz;
  } side_b_t;

  logic [D-1:0] box_w_r, box_h_r, min_w_r, min_h_r;
  logic         crop_en_r;

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_w_r   <= D'(128);
      box_h_r   <= D'(128);
      crop_en_r <= 1'b0;
      min_w_r   <= '0;
      min_h_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tscw_pkg::REG_BOX_WIDTH:   box_w_r   <= cfg_data;
        tscw_pkg::REG_BOX_HEIGHT:  box_h_r   <= cfg_data;
        tscw_pkg::REG_CROP_ENABLE: crop_en_r <= cfg_data[0];
        tscw_pkg::REG_MIN_WIDTH:   min_w_r   <= cfg_data;
        tscw_pkg::REG_MIN_HEIGHT:  min_h_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits: a, b, divider A line, c, d, e, divider B line, output
  logic         va_r, vb_r, vc_r, vd_r, ve_r, out_valid_r;
  logic [L-1:0] vda_r, vdb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vda_r       <= '0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      vdb_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      va_r        <= in_valid;
      vb_r        <= va_r;
      vda_r       <= {vda_r[L-2:0], vb_r};
      vc_r        <= vda_r[L-1];
      vd_r        <= vc_r;
      ve_r        <= vd_r;
      vdb_r       <= {vdb_r[L-2:0], ve_r};
      out_valid_r <= vdb_r[L-1];
    end
  end
  assign out_valid = out_valid_r;

  // stage a: capture
  logic [D-1:0] a_fw_r, a_fh_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_fw_r <= in_data.full_width;
      a_fh_r <= in_data.full_height;
    end
  end

  // stage b: numerators of the box fit
  logic [N-1:0] b_nw_r, b_nh_r;
  side_a_t      b_side_r;
  logic [2*D-1:0] pw, ph;
  assign pw = box_h_r * a_fw_r;
  assign ph = box_w_r * a_fh_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_nw_r       <= {1'b0, pw} + N'(a_fh_r) - N'(1);
      b_nh_r       <= {1'b0, ph} + N'(a_fw_r) - N'(1);
      b_side_r.fw  <= a_fw_r;
      b_side_r.fh  <= a_fh_r;
      b_side_r.err <= (a_fw_r == '0) || (a_fh_r == '0);
    end
  end

  logic [N-1:0] qw, qh;
  tscw_div u_div_w (.clk(clk), .adv(adv), .num(b_nw_r), .den(b_side_r.fh), .quo(qw));
  tscw_div u_div_h (.clk(clk), .adv(adv), .num(b_nh_r), .den(b_side_r.fw), .quo(qh));

  side_a_t sa_r [L];
  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r[0] <= b_side_r;
      for (int k = 1; k < L; k++) begin
        sa_r[k] <= sa_r[k-1];
      end
    end
  end

  // stage c: fit and bound the target size
  side_a_t      sa;
  logic [N-1:0] tw_raw, th_raw;
  logic [D-1:0] tw_c, th_c;
  assign sa = sa_r[L-1];

  always_comb begin
    priority if (qw <= N'(box_w_r) && (!crop_en_r || qw >= N'(min_w_r))) begin
      tw_raw = qw;
      th_raw = N'(box_h_r);
    end else if (crop_en_r && qw < N'(min_w_r)) begin
      tw_raw = N'(min_w_r);
      th_raw = N'(box_h_r);
    end else begin
      tw_raw = N'(box_w_r);
      th_raw = (!crop_en_r || qh >= N'(min_h_r)) ? qh : N'(min_h_r);
    end
    tw_c = (tw_raw > N'(sa.fw)) ? sa.fw : tw_raw[D-1:0];
    th_c = (th_raw > N'(sa.fh)) ? sa.fh : th_raw[D-1:0];
  end

  side_b_t c_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_r.tw  <= tw_c;
      c_r.th  <= th_c;
      c_r.fw  <= sa.fw;
      c_r.fh  <= sa.fh;
      c_r.err <= sa.err;
      c_r.gt  <= 1'b0;
      c_r.dz  <= 1'b0;
    end
  end

  // stage d: cross products for the aspect compare
  side_b_t        d_r;
  logic [2*D-1:0] d_p1_r, d_p2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      d_r    <= c_r;
      d_p1_r <= c_r.tw * c_r.fh;
      d_p2_r <= c_r.th * c_r.fw;
    end
  end

  // stage e: choose which side of the window to divide out
  side_b_t      e_r;
  logic [N-1:0] e_num_r;
  logic [D-1:0] e_den_r;
  logic         gt_e;
  assign gt_e = d_p1_r > d_p2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r     <= d_r;
      e_r.gt  <= gt_e;
      e_r.dz  <= gt_e ? (box_w_r == '0) : (box_h_r == '0);
      e_num_r <= gt_e ? ({1'b0, d_p2_r} + N'(box_w_r) - N'(1))
                      : ({1'b0, d_p1_r} + N'(box_h_r) - N'(1));
      e_den_r <= gt_e ? box_w_r : box_h_r;
    end
  end

  logic [N-1:0] qa;
  tscw_div u_div_a (.clk(clk), .adv(adv), .num(e_num_r), .den(e_den_r), .quo(qa));

  side_b_t sb_r [L];
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= e_r;
      for (int k = 1; k < L; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // output stage: crop window cases
  side_b_t        sb;
  logic [N-1:0]   q, aw, ah;
  logic [D-1:0]   hx, hy, mhx, mhy, dx, dy;
  tscw_pkg::out_t res;
  assign sb = sb_r[L-1];

  always_comb begin
    q   = sb.dz ? '0 : qa;
    aw  = sb.gt ? N'(sb.fw) : q;
    ah  = sb.gt ? q : N'(sb.fh);
    hx  = sb.fw >> 1;
    hy  = sb.fh >> 1;
    mhx = min_w_r >> 1;
    mhy = min_h_r >> 1;
    dx  = sb.fw - aw[D-1:0];
    dy  = sb.fh - ah[D-1:0];

    res               = '0;
    res.target_width  = sb.tw;
    res.target_height = sb.th;
    priority if (!crop_en_r || (sb.fw <= min_w_r && sb.fh <= min_h_r)) begin
      res.area_width  = sb.fw;
      res.area_height = sb.fh;
    end else if (sb.fw <= min_w_r) begin
      res.area_y      = (hy > mhy) ? (hy - mhy) : '0;
      res.area_width  = sb.fw;
      res.area_height = min_h_r;
    end else if (sb.fh <= min_h_r) begin
      res.area_x      = (hx > mhx) ? (hx - mhx) : '0;
      res.area_width  = min_w_r;
      res.area_height = sb.fh;
    end else begin
      res.area_x      = (aw <= N'(sb.fw)) ? (dx >> 1) : '0;
      res.area_y      = (ah <= N'(sb.fh)) ? (dy >> 1) : '0;
      res.area_width  = (aw > N'({D{1'b1}})) ? {D{1'b1}} : aw[D-1:0];
      res.area_height = (ah > N'({D{1'b1}})) ? {D{1'b1}} : ah[D-1:0];
    end
    if (sb.err) begin
      res            = '0;
      res.size_error = 1'b1;
    end
  end

  tscw_pkg::out_t out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end
  assign out_data = out_r;

endmodule
